FILE: hdl/dff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dff_pkg;

  localparam int DEVICES = 2;
  localparam int ENTRIES = 16;

  localparam int DEPTH  = DEVICES * ENTRIES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  localparam int SRC_W = 64;
  localparam int SEQ_W = 8;

  typedef logic [SRC_W-1:0] src_t;
  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DEV_W-1:0] dev_t;

  typedef struct packed {
    src_t src;
    seq_t seq;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/dff_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dff_in_if
  import dff_pkg::*;
();
  logic valid;
  logic ready;
  logic device_index;
  src_t source_address;
  seq_t sequence_number;

  modport source (output valid, output device_index, output source_address,
                  output sequence_number, input ready);
  modport sink (input valid, input device_index, input source_address,
                input sequence_number, output ready);
endinterface

interface dff_out_if
  import dff_pkg::*;
();
  logic valid;
  logic ready;
  logic deliver;
  logic new_source;
  logic table_full;

  modport source (output valid, output deliver, output new_source,
                  output table_full, input ready);
  modport sink (input valid, input deliver, input new_source,
                input table_full, output ready);
endinterface

`default_nettype wire

FILE: hdl/duplicate_frame_filter.sv
// duplicate_frame_filter: drops received frames whose source and sequence
// number match the last ones seen from that source on the same radio.
// in_ch carries one request per frame (radio index, source address,
// sequence number); out_ch returns one result per request: deliver,
// new_source, table_full. Both channels move a request when valid and
// ready are high at a rising edge of clk.
// Each radio has a table of ENTRIES sources held in one shared memory with
// one registered read port. The sequencer scans the entries in order,
// reading each entry in S_READ and comparing it in S_CMP; a matching
// source ends the scan, and an unknown source is appended while its
// table has room, else table_full is set. One request is worked on at a
// time; in_ch.ready is high only while the sequencer is idle, so a new
// request is accepted at the earliest in the cycle after the previous
// result is loaded.
// The result sits in an output register, so a new request is accepted
// while an earlier result waits; a stalled receiver holds the finished
// result and the sequencer waits before writing the next one.
// rst_n (synchronous, active low) empties all tables by clearing the fill
// counts and drops any pending result; the memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module duplicate_frame_filter
  import dff_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  dff_in_if.sink     in_ch,
  dff_out_if.source  out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       dev_r;
  src_t       src_r;
  seq_t       seq_r;
  cnt_t       cnt_r, cnt_nxt;
  cnt_t       idx_r, idx_nxt;
  logic       res_deliver_r, res_deliver_nxt;
  logic       res_new_r, res_new_nxt;
  logic       res_full_r, res_full_nxt;

  logic       out_valid_r;
  logic       out_deliver_r;
  logic       out_new_r;
  logic       out_full_r;

  cnt_t       fill_r [DEVICES];
  entry_t     mem_r [DEPTH];
  entry_t     rd_data_r;

  logic       mem_we;
  addr_t      mem_addr;
  logic       fill_we;
  dev_t       dev_idx;
  dev_t       in_dev_idx;
  logic       accept;
  logic       load_out;

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign load_out   = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign dev_idx    = DEV_W'(dev_r);
  assign in_dev_idx = DEV_W'(in_ch.device_index);
  assign mem_addr   = ADDR_W'(int'(dev_r) * ENTRIES + int'(idx_r));

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    res_deliver_nxt = res_deliver_r;
    res_new_nxt     = res_new_r;
    res_full_nxt    = res_full_r;
    mem_we          = 1'b0;
    fill_we         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_deliver_nxt = 1'b1;
          res_new_nxt     = 1'b0;
          res_full_nxt    = 1'b0;
          idx_nxt         = '0;
          cnt_nxt         = fill_r[in_dev_idx];
          if (int'(in_ch.device_index) < DEVICES) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_READ: begin
        if (idx_r == cnt_r) begin
          if (int'(cnt_r) < ENTRIES) begin
            mem_we      = 1'b1;
            fill_we     = 1'b1;
            res_new_nxt = 1'b1;
          end else begin
            res_full_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_data_r.src == src_r) begin
          if (rd_data_r.seq == seq_r) begin
            res_deliver_nxt = 1'b0;
          end else begin
            mem_we = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + cnt_t'(1);
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // shared table memory, one port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= '{src: src_r, seq: seq_r};
    end
    rd_data_r <= mem_r[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dev_r <= in_ch.device_index;
      src_r <= in_ch.source_address;
      seq_r <= in_ch.sequence_number;
    end
    cnt_r         <= cnt_nxt;
    idx_r         <= idx_nxt;
    res_deliver_r <= res_deliver_nxt;
    res_new_r     <= res_new_nxt;
    res_full_r    <= res_full_nxt;
    if (load_out) begin
      out_deliver_r <= res_deliver_r;
      out_new_r     <= res_new_r;
      out_full_r    <= res_full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int d = 0; d < DEVICES; d++) begin
        fill_r[d] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (fill_we) begin
        fill_r[dev_idx] <= cnt_r + cnt_t'(1);
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.deliver    = out_deliver_r;
  assign out_ch.new_source = out_new_r;
  assign out_ch.table_full = out_full_r;

endmodule

`default_nettype wire

FILE: verif/dff_checker.sv
`timescale 1ns / 1ps

module dff_checker
  import dff_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dff_in_if    in_mon,
  dff_out_if   out_mon,
  output int   mismatch_count,
  output int   outstanding
);

  typedef struct packed {
    logic deliver;
    logic new_source;
    logic table_full;
  } verdict_t;

  src_t        stored_src [DEVICES][ENTRIES];
  seq_t        stored_seq [DEVICES][ENTRIES];
  int unsigned stored_cnt [DEVICES];
  verdict_t    expected_verdicts [$];

  function automatic verdict_t screen_frame(input dev_t dev, input src_t src, input seq_t seq);
    verdict_t v;
    bit hit;
    v.deliver    = 1'b1;
    v.new_source = 1'b0;
    v.table_full = 1'b0;
    hit = 1'b0;
    if (dev < DEVICES) begin
      for (int i = 0; i < stored_cnt[dev]; i++) begin
        if (!hit && stored_src[dev][i] == src) begin
          hit = 1'b1;
          if (stored_seq[dev][i] == seq) begin
            v.deliver = 1'b0;
          end else begin
            stored_seq[dev][i] = seq;
          end
        end
      end
      if (!hit) begin
        if (stored_cnt[dev] < ENTRIES) begin
          stored_src[dev][stored_cnt[dev]] = src;
          stored_seq[dev][stored_cnt[dev]] = seq;
          stored_cnt[dev]++;
          v.new_source = 1'b1;
        end else begin
          v.table_full = 1'b1;
        end
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      foreach (stored_cnt[d]) stored_cnt[d] = 0;
      expected_verdicts.delete();
      mismatch_count <= 0;
      outstanding <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with no request waiting");
          errs++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_mon.deliver !== want.deliver) begin
            $error("deliver: expected %0b, got %0b", want.deliver, out_mon.deliver);
            errs++;
          end
          if (out_mon.new_source !== want.new_source) begin
            $error("new_source: expected %0b, got %0b", want.new_source, out_mon.new_source);
            errs++;
          end
          if (out_mon.table_full !== want.table_full) begin
            $error("table_full: expected %0b, got %0b", want.table_full, out_mon.table_full);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_verdicts.push_back(screen_frame(in_mon.device_index, in_mon.source_address,
                                                 in_mon.sequence_number));
      end
      mismatch_count <= mismatch_count + errs;
      outstanding <= expected_verdicts.size();
    end
  end

endmodule

FILE: verif/tb_duplicate_frame_filter.sv
`timescale 1ns / 1ps

module tb_duplicate_frame_filter;
  import dff_pkg::*;

  localparam int POOL = ENTRIES + 8;
  localparam int RANDOM_FRAMES = 1800;

  logic clk;
  logic rst_n;
  bit   calm;
  bit   squeeze_go;
  bit   squeeze_done;
  int   mismatch_count;
  int   outstanding;

  dff_in_if  in_ch ();
  dff_out_if out_ch ();

  duplicate_frame_filter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dff_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int idle_len(input int longest);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, longest);
  endfunction

  task automatic send_frame(input logic dev, input src_t src, input seq_t seq);
    int pause;
    pause = calm ? 0 : idle_len(40);
    if (pause > 0) begin
      in_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.device_index    <= dev;
    in_ch.source_address  <= src;
    in_ch.sequence_number <= seq;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // result side
  initial begin : sink_side
    int stall;
    int run;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (squeeze_go && !squeeze_done) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        stall = calm ? 0 : idle_len(60);
        run   = calm ? 1 : $urandom_range(1, 8);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : source_side
    src_t pool [2][POOL];
    seq_t recent [2][POOL];
    int   p;
    int   r;
    int   waited;
    logic d;
    src_t s;
    seq_t q;

    in_ch.valid           <= 1'b0;
    in_ch.device_index    <= 1'b0;
    in_ch.source_address  <= '0;
    in_ch.sequence_number <= '0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // new and duplicate on both address extremes, update on the all-zero one
    send_frame(1'b0, '0, 8'h00);
    send_frame(1'b0, '0, 8'h00);
    send_frame(1'b0, '0, 8'hFF);
    send_frame(1'b0, '1, 8'hFF);
    send_frame(1'b0, '1, 8'hFF);
    // same address on the other radio is a separate table
    send_frame(1'b1, '0, 8'h00);
    send_frame(1'b1, '1, 8'h55);
    send_frame(1'b1, {32{2'b10}}, 8'hAA);
    // fill radio 0
    for (int k = 0; k < ENTRIES - 2; k++) begin
      send_frame(1'b0, src_t'(1) << (4 * k + 1), seq_t'(k));
    end
    // table full, then known sources still filtered
    send_frame(1'b0, 64'h0123_4567_89AB_CDEF, 8'h01);
    send_frame(1'b0, '0, 8'hFF);
    send_frame(1'b0, '1, 8'h00);

    pool[0][0] = '0;
    pool[0][1] = '1;
    for (int k = 0; k < ENTRIES - 2; k++) pool[0][k + 2] = src_t'(1) << (4 * k + 1);
    for (int k = ENTRIES; k < POOL; k++) pool[0][k] = {$urandom, $urandom};
    pool[1][0] = '0;
    pool[1][1] = '1;
    pool[1][2] = {32{2'b10}};
    for (int k = 3; k < POOL; k++) pool[1][k] = {$urandom, $urandom};
    foreach (recent[i, j]) recent[i][j] = seq_t'($urandom);

    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      if (n == 400) squeeze_go = 1'b1;
      calm = (n >= 900 && n < 1100);
      d = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 10) begin
        s = {$urandom, $urandom};
        q = seq_t'($urandom);
      end else begin
        p = $urandom_range(0, POOL - 1);
        s = pool[d][p];
        r = $urandom_range(0, 99);
        if (r < 40) q = recent[d][p];
        else if (r < 60) q = recent[d][p] + seq_t'(1);
        else q = seq_t'($urandom);
        recent[d][p] = q;
      end
      send_frame(d, s, q);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;
    @(posedge clk);

    waited = 0;
    while (outstanding != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
